>>> design/per_host_traffic_counter_table_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef PER_HOST_TRAFFIC_COUNTER_TABLE_ASSERT_SVH
`define PER_HOST_TRAFFIC_COUNTER_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PHTC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PHTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/phtc_pkg.sv
// Shared types, constants and functions of the per-host traffic counter table.
`default_nettype none
package phtc_pkg;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 144;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [31:0] PRIV_MASK_A = 32'hFF000000;
    localparam logic [31:0] PRIV_NET_A  = 32'h0A000000;
    localparam logic [31:0] PRIV_MASK_B = 32'hFFF00000;
    localparam logic [31:0] PRIV_NET_B  = 32'hAC100000;
    localparam logic [31:0] PRIV_MASK_C = 32'hFFFF0000;
    localparam logic [31:0] PRIV_NET_C  = 32'hC0A80000;
    localparam logic [31:0] LOOP_NET    = 32'h7F000000;

    localparam logic [2:0] REG_ENTRY_LIMIT = 3'd0;
    localparam logic [6:0] ENTRY_LIMIT_RST = 7'd64;

    typedef struct packed {
        logic match;
    } phtc_alu_status_t;

    function automatic logic addr_private(input logic [31:0] a);
        return ((a & PRIV_MASK_A) == PRIV_NET_A) || ((a & PRIV_MASK_B) == PRIV_NET_B) ||
               ((a & PRIV_MASK_C) == PRIV_NET_C) || ((a & PRIV_MASK_A) == LOOP_NET);
    endfunction

    // Fold of the byte-swapped address: low half xor high half.
    function automatic logic [15:0] addr_hash(input logic [31:0] a);
        return {a[23:16] ^ a[7:0], a[31:24] ^ a[15:8]};
    endfunction

endpackage
`default_nettype wire

>>> design/phtc_alu.sv
// Shared counter adder and address comparator.
`default_nettype none
module phtc_alu (
    input  wire logic [31:0]            count,
    input  wire logic [15:0]            length,
    input  wire logic [31:0]            key_a,
    input  wire logic [31:0]            key_b,
    output logic [31:0]                 sum,
    output phtc_pkg::phtc_alu_status_t  status
);
    import phtc_pkg::*;

    assign sum          = count + {16'd0, length};
    assign status.match = (key_a == key_b);

endmodule
`default_nettype wire

>>> design/per_host_traffic_counter_table.sv
// Top level: hashed per-source byte counter table with sequencer and storage.
// A packet beat is consumed in the idle state when filtered out; else it reads
// the bucket head, walks the chain entries until a match or the chain end, and
// updates the matched entry or inserts a new one while below the entry limit.
// A drain beat is accepted, then each bucket head is read and every entry in its
// chain emitted (held while the output stalls), then the table is cleared; no
// beat is taken meanwhile. Results leave through one output register.
`default_nettype none
module per_host_traffic_counter_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int BUCKET_COUNT  = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // ether_type[15:0], src_ip[47:16], dst_ip[79:48], src_mac[127:80],
    // ip_length[143:128], ip_protocol[151:144]
    input  wire logic [phtc_pkg::S_DATA_W-1:0] s_tdata,
    // command[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // host_ip[31:0], host_mac[79:32], tcp_total[111:80], udp_total[143:112]
    output logic [phtc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import phtc_pkg::*;

    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_HEAD    = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_INSERT  = 3'd3;
    localparam logic [2:0] S_DRAIN_H = 3'd4;
    localparam logic [2:0] S_DRAIN_E = 3'd5;
    localparam logic [2:0] S_DDONE   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [6:0]    limit_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [BUCKET_COUNT-1:0] bvalid_reg;

    logic [31:0] src_reg, src_next;
    logic [47:0] mac_reg, mac_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  proto_reg, proto_next;

    logic [EW-1:0] head_mem [BUCKET_COUNT];
    logic [EW-1:0] head_q;
    logic [BW-1:0] hd_raddr;
    logic          hd_we;

    logic [31:0]   e_addr [TABLE_ENTRIES];
    logic [47:0]   e_mac  [TABLE_ENTRIES];
    logic [31:0]   e_tcp  [TABLE_ENTRIES];
    logic [31:0]   e_udp  [TABLE_ENTRIES];
    logic [EW-1:0] e_link [TABLE_ENTRIES];
    logic          e_lval [TABLE_ENTRIES];
    logic [31:0]   q_addr, q_tcp, q_udp;
    logic [47:0]   q_mac;
    logic [EW-1:0] q_link;
    logic          q_lval;
    logic [EW-1:0] ent_raddr, ent_waddr;
    logic          ent_we;
    logic [31:0]   w_addr, w_tcp, w_udp;
    logic [47:0]   w_mac;
    logic [EW-1:0] w_link;
    logic          w_lval;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic             set_bvalid, clr_bvalid;
    logic [31:0]      alu_count, alu_sum;
    phtc_alu_status_t alu_status;
    logic             out_free, accept, filt_pass;
    logic [31:0]      in_src, in_dst;
    logic [15:0]      in_hash;

    assign in_src    = s_tdata[47:16];
    assign in_dst    = s_tdata[79:48];
    assign in_hash   = addr_hash(in_src);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign filt_pass = (s_tdata[15:0] == ETH_IPV4) && addr_private(in_src) &&
                       !addr_private(in_dst);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign alu_count = (proto_reg == PROTO_TCP) ? q_tcp : q_udp;

    phtc_alu u_alu (
        .count  (alu_count),
        .length (len_reg),
        .key_a  (q_addr),
        .key_b  (src_reg),
        .sum    (alu_sum),
        .status (alu_status)
    );

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        emit_next     = emit_reg;
        bucket_next   = bucket_reg;
        cur_next      = cur_reg;
        src_next      = src_reg;
        mac_next      = mac_reg;
        len_next      = len_reg;
        proto_next    = proto_reg;
        hd_raddr      = bucket_reg;
        hd_we         = 1'b0;
        ent_raddr     = cur_reg;
        ent_waddr     = cur_reg;
        ent_we        = 1'b0;
        w_addr        = q_addr;
        w_mac         = q_mac;
        w_tcp         = q_tcp;
        w_udp         = q_udp;
        w_link        = q_link;
        w_lval        = q_lval;
        set_bvalid    = 1'b0;
        clr_bvalid    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    src_next   = in_src;
                    mac_next   = s_tdata[127:80];
                    len_next   = s_tdata[143:128];
                    proto_next = s_tdata[151:144];
                    if (s_tuser)
                    begin
                        bucket_next = '0;
                        hd_raddr    = '0;
                        emit_next   = '0;
                        state_next  = S_DRAIN_H;
                    end
                    else if (filt_pass)
                    begin
                        bucket_next = in_hash[BW-1:0];
                        hd_raddr    = in_hash[BW-1:0];
                        state_next  = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                if (bvalid_reg[bucket_reg])
                begin
                    ent_raddr  = head_q;
                    cur_next   = head_q;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_CMP:
            begin
                if (alu_status.match)
                begin
                    if (proto_reg == PROTO_TCP)
                    begin
                        w_tcp  = alu_sum;
                        ent_we = 1'b1;
                    end
                    else if (proto_reg == PROTO_UDP)
                    begin
                        w_udp  = alu_sum;
                        ent_we = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (q_lval)
                begin
                    ent_raddr = q_link;
                    cur_next  = q_link;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if ((32'(used_reg) < 32'(limit_reg)) && (32'(used_reg) < TABLE_ENTRIES))
                begin
                    ent_waddr  = used_reg[EW-1:0];
                    ent_we     = 1'b1;
                    w_addr     = src_reg;
                    w_mac      = mac_reg;
                    w_tcp      = (proto_reg == PROTO_TCP) ? {16'd0, len_reg} : 32'd0;
                    w_udp      = (proto_reg == PROTO_UDP) ? {16'd0, len_reg} : 32'd0;
                    w_link     = head_q;
                    w_lval     = bvalid_reg[bucket_reg];
                    hd_we      = 1'b1;
                    set_bvalid = 1'b1;
                    used_next  = used_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            S_DRAIN_H:
            begin
                if (bvalid_reg[bucket_reg])
                begin
                    ent_raddr  = head_q;
                    cur_next   = head_q;
                    state_next = S_DRAIN_E;
                end
                else if (bucket_reg == BW'(BUCKET_COUNT - 1))
                begin
                    state_next = S_DDONE;
                end
                else
                begin
                    bucket_next = bucket_reg + BW'(1);
                    hd_raddr    = bucket_reg + BW'(1);
                end
            end
            S_DRAIN_E:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {q_udp, q_tcp, q_mac, q_addr};
                    m_tlast_next  = (emit_reg + CW'(1)) == used_reg;
                    emit_next     = emit_reg + CW'(1);
                    if (q_lval)
                    begin
                        ent_raddr = q_link;
                        cur_next  = q_link;
                    end
                    else if (bucket_reg == BW'(BUCKET_COUNT - 1))
                    begin
                        state_next = S_DDONE;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + BW'(1);
                        hd_raddr    = bucket_reg + BW'(1);
                        state_next  = S_DRAIN_H;
                    end
                end
            end
            S_DDONE:
            begin
                clr_bvalid = 1'b1;
                used_next  = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            emit_reg     <= '0;
            bvalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= ENTRY_LIMIT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            emit_reg     <= emit_next;
            m_tvalid_reg <= m_tvalid_next;
            if (clr_bvalid)
            begin
                bvalid_reg <= '0;
            end
            else if (set_bvalid)
            begin
                bvalid_reg[bucket_reg] <= 1'b1;
            end
            if (psel && penable && pwrite && (paddr == REG_ENTRY_LIMIT))
            begin
                limit_reg <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg  <= bucket_next;
        cur_reg     <= cur_next;
        src_reg     <= src_next;
        mac_reg     <= mac_next;
        len_reg     <= len_next;
        proto_reg   <= proto_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            head_mem[bucket_reg] <= used_reg[EW-1:0];
        end
        head_q <= head_mem[hd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            e_addr[ent_waddr] <= w_addr;
            e_mac[ent_waddr]  <= w_mac;
            e_tcp[ent_waddr]  <= w_tcp;
            e_udp[ent_waddr]  <= w_udp;
            e_link[ent_waddr] <= w_link;
            e_lval[ent_waddr] <= w_lval;
        end
        q_addr <= e_addr[ent_raddr];
        q_mac  <= e_mac[ent_raddr];
        q_tcp  <= e_tcp[ent_raddr];
        q_udp  <= e_udp[ent_raddr];
        q_link <= e_link[ent_raddr];
        q_lval <= e_lval[ent_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_ENTRY_LIMIT) ? {25'd0, limit_reg} : 32'd0;

endmodule
`default_nettype wire

>>> design/phtc_checker.sv
// Port-level checker for the per-host traffic counter table, with its bind.
`default_nettype none
`include "per_host_traffic_counter_table_assert.svh"
module phtc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [phtc_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import phtc_pkg::*;

    `PHTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped")
    `PHTC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tlast), "stalled output changed")
    `PHTC_ASSERT_NEXT(a_drain_busy, s_tvalid && s_tready && s_tuser, !s_tready, "drain did not block input")
    `PHTC_ASSERT_NEXT(a_last_gap, m_tvalid && m_tready && m_tlast && s_tready, !m_tvalid,
        "beat after last record")

endmodule

bind per_host_traffic_counter_table phtc_checker u_phtc_checker (.*);
`default_nettype wire

>>> sim/host_table_checker.sv
// Checker for the per-host traffic counter table: predicts drain records and compares beats.
`timescale 1ns / 1ps
module host_table_checker
    import phtc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DATA_W-1:0]   m_tdata,
    input  wire logic                  m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output int                         fail_count,
    output int                         records_pending
);

    localparam int ENTRIES = 64;
    localparam int BUCKETS = 256;

    typedef struct packed {
        logic        last;
        logic [31:0] udp;
        logic [31:0] tcp;
        logic [47:0] mac;
        logic [31:0] ip;
    } host_record_t;

    logic [6:0]  head_idx [BUCKETS];
    logic        head_ok [BUCKETS];
    logic [31:0] host_addr [ENTRIES];
    logic [47:0] host_mac [ENTRIES];
    logic [31:0] host_tcp [ENTRIES];
    logic [31:0] host_udp [ENTRIES];
    logic [6:0]  next_idx [ENTRIES];
    logic        next_ok [ENTRIES];
    int          hosts_used;
    logic [6:0]  host_limit;
    host_record_t drain_records [$];

    assign records_pending = drain_records.size();

    function automatic logic is_private(input logic [31:0] a);
        return (a[31:24] == 8'h0A) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8) ||
               (a[31:24] == 8'h7F);
    endfunction

    task automatic clear_hosts();
        for (int b = 0; b < BUCKETS; b++)
        begin
            head_ok[b] = 1'b0;
            head_idx[b] = '0;
        end
        for (int e = 0; e < ENTRIES; e++)
            next_ok[e] = 1'b0;
        hosts_used = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic drain_hosts();
        host_record_t rec;
        int n;
        int steps;
        logic ok;
        int e;
        n = 0;
        for (int b = 0; b < BUCKETS; b++)
        begin
            ok = head_ok[b];
            e = head_idx[b];
            steps = 0;
            while (ok && e < ENTRIES && steps < ENTRIES && n < ENTRIES)
            begin
                rec = '{last: 1'b0, udp: host_udp[e], tcp: host_tcp[e],
                        mac: host_mac[e], ip: host_addr[e]};
                drain_records.push_back(rec);
                n++;
                steps++;
                ok = next_ok[e];
                e = next_idx[e];
            end
        end
        if (n > 0)
            drain_records[drain_records.size() - 1].last = 1'b1;
        clear_hosts();
    endtask

    task automatic account_packet(input logic [S_DATA_W-1:0] d);
        logic [15:0] etype;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] len;
        logic [7:0]  proto;
        logic [7:0]  b;
        logic        ok;
        int          e;
        int          steps;
        int          lim;
        etype = d[15:0];
        src = d[47:16];
        dst = d[79:48];
        len = d[143:128];
        proto = d[151:144];
        if (etype != ETH_IPV4 || !is_private(src) || is_private(dst))
            return;
        b = src[31:24] ^ src[15:8];
        ok = head_ok[b];
        e = head_idx[b];
        steps = 0;
        lim = (host_limit < ENTRIES) ? host_limit : ENTRIES;
        while (ok && e < ENTRIES && steps < ENTRIES)
        begin
            if (host_addr[e] == src)
            begin
                if (proto == PROTO_TCP)
                    host_tcp[e] = host_tcp[e] + 32'(len);
                else if (proto == PROTO_UDP)
                    host_udp[e] = host_udp[e] + 32'(len);
                return;
            end
            steps++;
            ok = next_ok[e];
            e = next_idx[e];
        end
        if (hosts_used < lim)
        begin
            host_addr[hosts_used] = src;
            host_mac[hosts_used] = d[127:80];
            host_tcp[hosts_used] = (proto == PROTO_TCP) ? 32'(len) : 32'd0;
            host_udp[hosts_used] = (proto == PROTO_UDP) ? 32'(len) : 32'd0;
            next_idx[hosts_used] = head_idx[b];
            next_ok[hosts_used] = head_ok[b];
            head_idx[b] = 7'(hosts_used);
            head_ok[b] = 1'b1;
            hosts_used++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        host_record_t want;
        if (!rst_n)
        begin
            clear_hosts();
            host_limit = ENTRY_LIMIT_RST;
            drain_records.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_ENTRY_LIMIT)
                host_limit = pwdata[6:0];
            if (m_tvalid && m_tready)
            begin
                if (drain_records.size() == 0)
                    report_mismatch("unexpected beat", m_tdata[63:0], '0);
                else
                begin
                    want = drain_records.pop_front();
                    if (m_tdata[31:0] !== want.ip)
                        report_mismatch("host_ip", 64'(m_tdata[31:0]), 64'(want.ip));
                    if (m_tdata[79:32] !== want.mac)
                        report_mismatch("host_mac", 64'(m_tdata[79:32]), 64'(want.mac));
                    if (m_tdata[111:80] !== want.tcp)
                        report_mismatch("tcp_total", 64'(m_tdata[111:80]), 64'(want.tcp));
                    if (m_tdata[143:112] !== want.udp)
                        report_mismatch("udp_total", 64'(m_tdata[143:112]), 64'(want.udp));
                    if (m_tlast !== want.last)
                        report_mismatch("last_record", 64'(m_tlast), 64'(want.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    drain_hosts();
                else
                    account_packet(s_tdata);
            end
        end
    end

endmodule

>>> sim/testbench.sv
// Stimulus and verdict for the per-host traffic counter table.
`timescale 1ns / 1ps
module testbench;
    import phtc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  records_pending;
    int                  idle_cycles = 0;
    bit                  quiet_mode = 1'b0;
    bit                  hold_sink = 1'b0;
    logic [31:0]         host_pool [16];

    always #5 clk = ~clk;

    per_host_traffic_counter_table dut (.*);

    host_table_checker checker_inst (.*);

    always @(posedge clk)
    begin
        if (!rst_n || hold_sink)
            m_tready <= 1'b0;
        else
            m_tready <= quiet_mode || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_limit(input logic [6:0] lim);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_ENTRY_LIMIT;
        pwdata <= {25'd0, lim};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (records_pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Leaves tvalid high on return; the next beat replaces it or settle drops it.
    task automatic send_beat(input logic cmd, input logic [15:0] etype,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [47:0] mac, input logic [15:0] len,
                             input logic [7:0] proto);
        while (!quiet_mode && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {proto, len, mac, dst, src, etype};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [31:0] private_addr();
        case ($urandom_range(3))
            0: return {8'h0A, 24'($urandom)};
            1: return {12'hAC1, 20'($urandom)};
            2: return {16'hC0A8, 16'($urandom)};
            default: return {8'h7F, 24'($urandom)};
        endcase
    endfunction

    task automatic random_beat(input int drain_pct);
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] etype;
        logic [7:0]  proto;
        int          r;
        r = $urandom_range(99);
        src = ($urandom_range(3) == 0) ? private_addr() : host_pool[$urandom_range(15)];
        dst = $urandom;
        if (dst[31:24] == 8'h0A || dst[31:24] == 8'h7F)
            dst[31] = 1'b1;
        etype = ETH_IPV4;
        case ($urandom_range(9))
            0, 1, 2, 3: proto = PROTO_TCP;
            4, 5, 6, 7: proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        if (r < drain_pct)
        begin
            send_beat(1'b1, 16'($urandom), $urandom, $urandom, {$urandom, 16'($urandom)},
                      16'($urandom), 8'($urandom));
            return;
        end
        if (r < drain_pct + 8)
        begin
            case ($urandom_range(2))
                0: etype = 16'($urandom);
                1: src = $urandom;
                default: dst = private_addr();
            endcase
        end
        send_beat(1'b0, etype, src, dst, {$urandom, 16'($urandom)}, 16'($urandom), proto);
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            host_pool[i] = private_addr();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(1'b1, 16'h0, 32'h0, 32'h0, 48'h0, 16'h0, 8'h0);
        send_beat(1'b0, ETH_IPV4, 32'h0A000001, 32'h08080808, 48'hFFFFFFFFFFFF,
                  16'hFFFF, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0A000001, 32'hFFFFFFFF, 48'h0, 16'hFFFF, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0A000001, 32'h0, 48'h0, 16'd100, PROTO_UDP);
        send_beat(1'b0, ETH_IPV4, 32'h0A000001, 32'h01020304, 48'h0, 16'd7, 8'd1);
        send_beat(1'b0, ETH_IPV4, 32'hAC1FFFFF, 32'h08080808, 48'h123456789ABC,
                  16'd5, 8'hFF);
        send_beat(1'b0, ETH_IPV4, 32'hC0A8FFFF, 32'hAC200000, 48'h1, 16'd9, PROTO_UDP);
        send_beat(1'b0, ETH_IPV4, 32'h7FFFFFFF, 32'h0B000000, 48'h2, 16'd1, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h01000A00, 32'h0B000000, 48'h2, 16'd1, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0B000001, 32'h08080808, 48'h3, 16'd1, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0A000002, 32'hC0A80001, 48'h3, 16'd1, PROTO_TCP);
        send_beat(1'b0, 16'h86DD, 32'h0A000003, 32'h08080808, 48'h3, 16'd1, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0A010000, 32'h08080808, 48'h4, 16'd3, PROTO_TCP);
        send_beat(1'b0, ETH_IPV4, 32'h0A000100, 32'h08080808, 48'h5, 16'd4, PROTO_UDP);
        send_beat(1'b1, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF,
                  16'hFFFF, 8'hFF);
        settle();

        write_limit(7'd2);
        for (int i = 0; i < 5; i++)
            send_beat(1'b0, ETH_IPV4, 32'hC0A80000 + i, 32'h08080808, 48'(i), 16'd10,
                      PROTO_TCP);
        settle();
        write_limit(7'd0);
        send_beat(1'b0, ETH_IPV4, 32'h0A0000FF, 32'h08080808, 48'h6, 16'd1, PROTO_UDP);
        send_beat(1'b1, 16'h0, 32'h0, 32'h0, 48'h0, 16'h0, 8'h0);
        settle();

        write_limit(7'd127);
        quiet_mode = 1'b1;
        for (int i = 0; i < 70; i++)
            send_beat(1'b0, ETH_IPV4, private_addr(), 32'h08080808, {$urandom, 16'($urandom)},
                      16'($urandom), PROTO_UDP);
        hold_sink = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
            end
            begin
                send_beat(1'b1, 16'h0, 32'h0, 32'h0, 48'h0, 16'h0, 8'h0);
                for (int i = 0; i < 4; i++)
                    send_beat(1'b0, ETH_IPV4, host_pool[i], 32'h08080808, 48'h7, 16'd2,
                              PROTO_TCP);
                s_tvalid <= 1'b0;
            end
        join
        quiet_mode = 1'b0;
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_limit((phase == 0) ? 7'd64 : (phase == 1) ? 7'd5 :
                        (phase == 2) ? 7'd100 : 7'd33);
            for (int i = 0; i < 100; i++)
                random_beat(4);
            send_beat(1'b1, 16'h0, 32'h0, 32'h0, 48'h0, 16'h0, 8'h0);
            settle();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
